### sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants
// Payload structs, format and register codes and the RGBA4444 repack function
// for the tiled texture swizzler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_W      = 22;
  localparam int unsigned DIM_REG_W   = 11;
  localparam int unsigned TILE_DIM    = 4;
  localparam int unsigned FACTOR_W    = 7;
  localparam int unsigned OFF_W       = 5;
  localparam int unsigned PAIR_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [DIM_REG_W-1:0] DIM_RESET      = 11'd1024;
  localparam logic [BYTE_W-1:0]    ALPHA_OPAQUE   = 8'hFF;
  localparam logic [PAIR_W-1:0]    RGB4_MASK      = 16'hFFF0;
  localparam logic [PAIR_W-1:0]    ALPHA3_MASK    = 16'h000E;
  localparam logic [FACTOR_W-1:0]  TILE32_BYTES   = 7'd64;

  typedef enum logic [1:0] {
    FMT_RGBA8888 = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_RGB565   = 2'd2,
    FMT_RGBA4444 = 2'd3
  } pixel_format_t;

  typedef enum logic [1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] src_byte0;
    logic [BYTE_W-1:0] src_byte1;
    logic [BYTE_W-1:0] src_byte2;
    logic [BYTE_W-1:0] src_byte3;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [BYTE_W-1:0] data_high;
    logic [BYTE_W-1:0] data_low;
    logic              last_write;
  } out_item_t;

  // RGBA4444 texel to RGB4A3: color nibbles move down, top three alpha bits
  // land in bits 14:12, bit 15 stays clear.
  function automatic logic [PAIR_W-1:0] repack_4a3(input logic [PAIR_W-1:0] t);
    logic [PAIR_W-1:0] r;
    r = ((t & RGB4_MASK) >> 4) | ((t & ALPHA3_MASK) << 11);
    return r;
  endfunction

endpackage

### sv/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front: pixel intake and classification
// Tracks column and row, drops ragged-edge pixels, works out the tile index,
// address factors and data pairs, and pushes one entry per kept pixel.
// ----------------------------------------------------------------------------
module tts_front import tts_pkg::*; #(
  parameter int unsigned MAX_DIM = 1024,
  parameter int unsigned TILE_W  = 18
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  in_item_t                           in_data,
  input  pixel_format_t                      pixel_format,
  input  logic [DIM_REG_W-1:0]               image_width,
  input  logic [DIM_REG_W-1:0]               image_height,
  input  logic                               full,
  output logic                               push,
  output logic [TILE_W+FACTOR_W+OFF_W+2*PAIR_W:0] push_entry
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam int unsigned TQ_W  = CNT_W - 1;

  typedef struct packed {
    logic                is32;
    logic [TILE_W-1:0]   tile;
    logic [FACTOR_W-1:0] factor;
    logic [OFF_W-1:0]    off;
    logic [PAIR_W-1:0]   d0;
    logic [PAIR_W-1:0]   d1;
  } entry_t;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;

  logic [CMP_W-1:0] w_ext, h_ext;
  logic [DIM_W-1:0] w, h, limit_x, limit_y, col_inc, row_inc;
  logic             small_x, small_y, kept, accept, is32;
  logic [2:0]       xc, yc;
  logic [TQ_W-1:0]  tiles_x, tx, ty;
  logic [1:0]       x, y;
  logic [BYTE_W-1:0] alpha;
  entry_t           entry;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    w_ext = CMP_W'(image_width);
    h_ext = CMP_W'(image_height);
    if (image_width == '0) begin
      w = DIM_W'(1);
    end else if (w_ext > CMP_W'(MAX_DIM)) begin
      w = DIM_W'(MAX_DIM);
    end else begin
      w = DIM_W'(w_ext);
    end
    if (image_height == '0) begin
      h = DIM_W'(1);
    end else if (h_ext > CMP_W'(MAX_DIM)) begin
      h = DIM_W'(MAX_DIM);
    end else begin
      h = DIM_W'(h_ext);
    end
  end

  always_comb begin
    small_x = w < DIM_W'(TILE_DIM);
    small_y = h < DIM_W'(TILE_DIM);
    limit_x = small_x ? w : {w[DIM_W-1:2], 2'b00};
    limit_y = small_y ? h : {h[DIM_W-1:2], 2'b00};
    xc      = small_x ? w[2:0] : 3'(TILE_DIM);
    yc      = small_y ? h[2:0] : 3'(TILE_DIM);
    tiles_x = small_x ? TQ_W'(1) : TQ_W'(w >> 2);
    tx      = TQ_W'(column_count >> 2);
    ty      = TQ_W'(row_count >> 2);
    x       = column_count[1:0];
    y       = row_count[1:0];
    kept    = (DIM_W'(column_count) < limit_x) && (DIM_W'(row_count) < limit_y);
    is32    = (pixel_format == FMT_RGBA8888) || (pixel_format == FMT_RGB888);
    alpha   = (pixel_format == FMT_RGBA8888) ? in_data.src_byte3 : ALPHA_OPAQUE;

    entry.is32 = is32;
    entry.tile = TILE_W'(ty) * TILE_W'(tiles_x) + TILE_W'(tx);
    if (is32) begin
      entry.factor = TILE32_BYTES;
      entry.off    = {y, x, 1'b0};
      entry.d0     = {alpha, in_data.src_byte0};
    end else begin
      entry.factor = FACTOR_W'({5'(xc * yc), 1'b0});
      entry.off    = {4'(4'(y) * 4'(xc) + 4'(x)), 1'b0};
      if (pixel_format == FMT_RGBA4444) begin
        entry.d0 = repack_4a3({in_data.src_byte0, in_data.src_byte1});
      end else begin
        entry.d0 = {in_data.src_byte0, in_data.src_byte1};
      end
    end
    entry.d1 = {in_data.src_byte1, in_data.src_byte2};
  end

  assign push       = accept && kept;
  assign push_entry = entry;

  // Raster walk: wrap column at width, row at height.
  always_comb begin
    col_inc           = DIM_W'(column_count) + DIM_W'(1);
    row_inc           = DIM_W'(row_count) + DIM_W'(1);
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (col_inc >= w) begin
        column_count_next = '0;
        row_count_next    = (row_inc >= h) ? '0 : CNT_W'(row_inc);
      end else begin
        column_count_next = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

### sv/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue: entry queue
// Short FIFO between the intake and the write generator.
// ----------------------------------------------------------------------------
module tts_queue import tts_pkg::*; #(
  parameter int unsigned WIDTH = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

### sv/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back: write generator
// Turns each queued entry into one or two tiled writes and holds them in the
// output register.
// ----------------------------------------------------------------------------
module tts_back import tts_pkg::*; #(
  parameter int unsigned TILE_W = 18
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    head_valid,
  input  logic [TILE_W+FACTOR_W+OFF_W+2*PAIR_W:0] head_data,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output out_item_t                               out_data
);

  localparam int unsigned SUM_W = (TILE_W + 8 > ADDR_W) ? TILE_W + 8 : ADDR_W;

  typedef struct packed {
    logic                is32;
    logic [TILE_W-1:0]   tile;
    logic [FACTOR_W-1:0] factor;
    logic [OFF_W-1:0]    off;
    logic [PAIR_W-1:0]   d0;
    logic [PAIR_W-1:0]   d1;
  } entry_t;

  entry_t           head;
  logic             phase;
  logic             advance, emit;
  logic [SUM_W-1:0] addr_sum;
  logic [PAIR_W-1:0] pair;

  assign head     = head_data;
  assign advance  = !out_valid || !out_stall;
  assign emit     = advance && head_valid;
  assign pop      = emit && (!head.is32 || phase);
  // Second write of a 32-bit pixel sits 32 bytes further on.
  assign addr_sum = SUM_W'(head.tile) * SUM_W'(head.factor) + SUM_W'({phase, head.off});
  assign pair     = phase ? head.d1 : head.d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      phase     <= head.is32 && !phase;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.dest_address <= addr_sum[ADDR_W-1:0];
      out_data.data_high    <= pair[PAIR_W-1:BYTE_W];
      out_data.data_low     <= pair[BYTE_W-1:0];
      out_data.last_write   <= !head.is32 || phase;
    end
  end

  a_phase_32bit: assert property (@(posedge clk) disable iff (rst)
      phase |-> (head_valid && head.is32))
    else $error("second write pending without a 32-bit entry");
  a_first_then_last: assert property (@(posedge clk) disable iff (rst)
      (emit && head.is32 && !phase) |=> phase)
    else $error("first 32-bit write not followed by its pair");

endmodule

### sv/texture_tile_swizzler_unit.sv
// ----------------------------------------------------------------------------
// texture_tile_swizzler_unit: 4x4 tiled texture swizzler
// Raster pixels in, tiled two-byte writes out, with an APB register port.
// ----------------------------------------------------------------------------
// Path: a kept pixel's first write reaches out_valid through the queue
//   and then the output register.
// Throughput: one pixel per cycle in 16-bit formats while out_stall is low;
//   a 32-bit pixel needs two writes; the single output write port sets this.
// Reset: counters at zero, queue empty, format RGBA8888, size 1024x1024.
// ----------------------------------------------------------------------------
module texture_tile_swizzler_unit import tts_pkg::*; #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // source pixel channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // tiled write channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Tile index spans both tile coordinates, one bit of headroom on each.
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned TILE_W  = 2 * (CNT_W - 1);
  localparam int unsigned ENTRY_W = 1 + TILE_W + FACTOR_W + OFF_W + 2 * PAIR_W;

  pixel_format_t        pixel_format;
  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  reg_index_t           reg_sel;
  logic                 reg_write;

  logic               q_full, q_push, q_pop, q_head_valid;
  logic [ENTRY_W-1:0] q_push_entry, q_head_entry;

  // --------------------------------------------------------------------------
  // Register port: always ready, write on the access phase.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGBA8888;
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (reg_write) begin
      case (reg_sel)
        REG_PIXEL_FORMAT: pixel_format <= pixel_format_t'(pwdata[1:0]);
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_REG_W-1:0];
        default:          ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PIXEL_FORMAT: prdata = PDATA_W'(pixel_format);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: walk the raster, classify each pixel, push kept ones.
  // --------------------------------------------------------------------------
  tts_front #(
    .MAX_DIM (MAX_DIM),
    .TILE_W  (TILE_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .pixel_format (pixel_format),
    .image_width  (image_width),
    .image_height (image_height),
    .full         (q_full),
    .push         (q_push),
    .push_entry   (q_push_entry)
  );

  // --------------------------------------------------------------------------
  // Queue: decouple intake stalls from output stalls.
  // --------------------------------------------------------------------------
  tts_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_entry)
  );

  // --------------------------------------------------------------------------
  // Back: issue one write per cycle while the output is not stalled, advance past an entry on its last write.
  // --------------------------------------------------------------------------
  tts_back #(
    .TILE_W (TILE_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_data  (q_head_entry),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
